/* sv/tmaf_pkg.sv */
// Shared definitions for the triangular moving average filter.
// Holds parameter defaults, width helpers and the divider status type.
// No dependencies; compile this file first.
package tmaf_pkg;

    localparam int WINDOW_MAX_DEF  = 15;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int CFG_BITS        = 4;
    localparam logic [CFG_BITS-1:0] WINDOW_RESET = CFG_BITS'(3);

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    function automatic int half_max(input int wmax);
        return (wmax - 1) >> 1;
    endfunction

    function automatic int half_bits(input int wmax);
        return (half_max(wmax) > 0) ? $clog2(half_max(wmax) + 1) : 1;
    endfunction

    function automatic int weight_bits(input int wmax);
        return $clog2(half_max(wmax) + 2);
    endfunction

    function automatic int divisor_bits(input int wmax);
        return $clog2((half_max(wmax) + 1) * (half_max(wmax) + 1) + 1);
    endfunction

    function automatic int sum_bits(input int wmax, input int sbits);
        return sbits + divisor_bits(wmax);
    endfunction

    // Clamps the written size, rounds it down to odd and returns the half width.
    function automatic int half_window(input logic [CFG_BITS-1:0] raw, input int wmax);
        int w;
        w = int'(raw);
        if (w > wmax)
        begin
            w = wmax;
        end
        if ((w % 2) == 0 && w > 0)
        begin
            w = w - 1;
        end
        if (w < 1)
        begin
            w = 1;
        end
        return (w - 1) >> 1;
    endfunction

endpackage

/* sv/tmaf_if.sv */
// Stream interfaces for the sample and result channels.
// Depends on tmaf_pkg for the default sample width.
interface tmaf_in_if #(
    parameter int SAMPLE_BITS = tmaf_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last_of_frame;

    modport source (output valid, sample, last_of_frame, input ready);
    modport sink   (input valid, sample, last_of_frame, output ready);
endinterface

interface tmaf_out_if #(
    parameter int SAMPLE_BITS = tmaf_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] smoothed;
    logic                          end_of_frame;

    modport source (output valid, smoothed, end_of_frame, input ready);
    modport sink   (input valid, smoothed, end_of_frame, output ready);
endinterface

/* sv/tmaf_cell.sv */
// One tap of the filter: a delay-line stage, its triangular weight and a
// stage of the registered partial-sum chain. Depends on tmaf_pkg.
module tmaf_cell #(
    parameter int IDX         = 0,
    parameter int WINDOW_MAX  = tmaf_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = tmaf_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                                   clk,
    input  logic                                                   rst_n,
    input  logic                                                   shift,
    input  logic [tmaf_pkg::half_bits(WINDOW_MAX)-1:0]             m,
    input  logic signed [SAMPLE_BITS-1:0]                          sample_in,
    output logic signed [SAMPLE_BITS-1:0]                          sample_out,
    input  logic signed [tmaf_pkg::sum_bits(WINDOW_MAX, SAMPLE_BITS)-1:0] acc_in,
    output logic signed [tmaf_pkg::sum_bits(WINDOW_MAX, SAMPLE_BITS)-1:0] acc_out
);
    import tmaf_pkg::*;

    localparam int WB   = weight_bits(WINDOW_MAX);
    localparam int SUMB = sum_bits(WINDOW_MAX, SAMPLE_BITS);
    localparam int PW   = SAMPLE_BITS + WB;
    localparam int IB   = $clog2(WINDOW_MAX + 1) + 1;

    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic signed [PW-1:0]          prod_reg;
    logic signed [SUMB-1:0]        acc_reg;

    logic [IB-1:0]        m_w;
    logic [IB-1:0]        offset;
    logic [WB-1:0]        weight;
    logic signed [PW-1:0] s_ext;
    logic signed [PW-1:0] w_ext;
    logic signed [PW-1:0] prod_next;
    logic signed [SUMB-1:0] acc_next;

    always_comb
    begin
        m_w    = IB'(m);
        offset = (IB'(IDX) > m_w) ? IB'(IDX) - m_w : m_w - IB'(IDX);
        if (IB'(IDX) <= (m_w << 1))
        begin
            weight = WB'(m_w + IB'(1) - offset);
        end
        else
        begin
            weight = '0;
        end
        s_ext     = PW'(sample_reg);
        w_ext     = PW'($signed({1'b0, weight}));
        prod_next = s_ext * w_ext;
        acc_next  = acc_in + SUMB'(prod_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_reg <= '0;
            prod_reg   <= '0;
            acc_reg    <= '0;
        end
        else
        begin
            if (shift)
            begin
                sample_reg <= sample_in;
            end
            prod_reg <= prod_next;
            acc_reg  <= acc_next;
        end
    end

    assign sample_out = sample_reg;
    assign acc_out    = acc_reg;

endmodule

/* sv/tmaf_div.sv */
// Restoring divider that scales the weighted sum, one quotient bit a cycle.
// Truncates toward zero. Depends on tmaf_pkg.
module tmaf_div #(
    parameter int WINDOW_MAX  = tmaf_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = tmaf_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                                   clk,
    input  logic                                                   rst_n,
    input  logic                                                   start,
    input  logic signed [tmaf_pkg::sum_bits(WINDOW_MAX, SAMPLE_BITS)-1:0] dividend,
    input  logic [tmaf_pkg::divisor_bits(WINDOW_MAX)-1:0]          divisor,
    output tmaf_pkg::div_status_t                                  status,
    output logic signed [SAMPLE_BITS-1:0]                          quotient
);
    import tmaf_pkg::*;

    localparam int DB   = divisor_bits(WINDOW_MAX);
    localparam int SUMB = sum_bits(WINDOW_MAX, SAMPLE_BITS);
    localparam int MAG  = SUMB - 1;
    localparam int CB   = $clog2(MAG);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic          neg_reg, neg_next;
    logic [CB-1:0] cnt_reg, cnt_next;
    logic [DB-1:0] rem_reg, rem_next;
    logic [DB-1:0] div_reg, div_next;
    logic [MAG-1:0] quo_reg, quo_next;

    logic [DB:0]    shifted;
    logic [DB:0]    diff;
    logic           fits;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        quo_next  = quo_reg;
        shifted   = {rem_reg, quo_reg[MAG-1]};
        diff      = shifted - {1'b0, div_reg};
        fits      = shifted >= {1'b0, div_reg};
        if (start)
        begin
            busy_next = 1'b1;
            neg_next  = dividend[SUMB-1];
            quo_next  = dividend[SUMB-1] ? MAG'(-dividend) : MAG'(dividend);
            rem_next  = '0;
            div_next  = divisor;
            cnt_next  = CB'(MAG - 1);
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[DB-1:0] : shifted[DB-1:0];
            quo_next = {quo_reg[MAG-2:0], fits};
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - CB'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            neg_reg  <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            div_reg  <= DB'(1);
            quo_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            neg_reg  <= neg_next;
            cnt_reg  <= cnt_next;
            rem_reg  <= rem_next;
            div_reg  <= div_next;
            quo_reg  <= quo_next;
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = neg_reg ? SAMPLE_BITS'(MAG'(0) - quo_reg) : SAMPLE_BITS'(quo_reg);

    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> rem_reg < div_reg)
        else $error("divider remainder reached the divisor");

    a_quotient_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> quo_reg <= (MAG'(1) << (SAMPLE_BITS - 1)))
        else $error("quotient magnitude exceeds the sample range");

    a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg)
        else $error("divider did not start");

endmodule

/* sv/triangular_moving_average_filter.sv */
// Channel   Dir  Payload                          Handshake
// samples   in   sample, last_of_frame            valid / ready
// results   out  smoothed, end_of_frame           valid / ready
// cfg       in   cfg_wdata (window size)          cfg_we, no read-back
// An item whose window is full passes through the partial-sum chain over the taps,
// then the bit-serial divider, before its result is emitted. Other items go
// straight to emitting their words, if they have any. The last sample of a frame
// also emits the trailing zero words of that frame.
// Reset is asynchronous and active low; results may stall freely, and a new
// sample is taken while the last word of the previous one waits in the output register.
// Depends on tmaf_pkg, tmaf_if, tmaf_cell and tmaf_div.
module triangular_moving_average_filter #(
    parameter int WINDOW_MAX  = tmaf_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = tmaf_pkg::SAMPLE_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [tmaf_pkg::CFG_BITS-1:0]  cfg_wdata,
    tmaf_in_if.sink                        samples,
    tmaf_out_if.source                     results
);
    import tmaf_pkg::*;

    localparam int MB   = half_bits(WINDOW_MAX);
    localparam int WB   = weight_bits(WINDOW_MAX);
    localparam int DB   = divisor_bits(WINDOW_MAX);
    localparam int SUMB = sum_bits(WINDOW_MAX, SAMPLE_BITS);
    localparam int PB   = $clog2(WINDOW_MAX + 1);
    localparam int CW   = (PB > MB + 1) ? PB : MB + 1;
    localparam int LAT  = WINDOW_MAX + 1;
    localparam int CB   = $clog2(LAT + 1);
    localparam logic [MB-1:0] M_RESET = MB'(half_window(WINDOW_RESET, WINDOW_MAX));

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SUM  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

    state_t                        state_reg, state_next;
    logic [MB-1:0]                 m_reg, m_next;
    logic [PB-1:0]                 pos_reg, pos_next;
    logic [CB-1:0]                 cnt_reg, cnt_next;
    logic [WB-1:0]                 pend_reg, pend_next;
    logic                          eof_reg, eof_next;
    logic signed [SAMPLE_BITS-1:0] value_reg, value_next;
    logic                          out_valid_reg, out_valid_next;
    logic signed [SAMPLE_BITS-1:0] out_data_reg, out_data_next;
    logic                          out_eof_reg, out_eof_next;

    logic                          shift;
    logic                          div_start;
    logic                          load_out;
    logic                          at_center;
    logic                          full;
    logic [CW-1:0]                 n_ext;
    logic [CW-1:0]                 m_ext;
    logic [WB-1:0]                 zeros;
    logic [WB-1:0]                 words;
    logic [DB-1:0]                 m_plus;
    logic [DB-1:0]                 dsor;
    div_status_t                   div_stat;
    logic signed [SAMPLE_BITS-1:0] div_quo;

    logic signed [SAMPLE_BITS-1:0] tap [WINDOW_MAX];
    logic signed [SUMB-1:0]        acc [WINDOW_MAX];

    for (genvar k = 0; k < WINDOW_MAX; k++)
    begin : g_cell
        logic signed [SAMPLE_BITS-1:0] s_in;
        logic signed [SUMB-1:0]        a_in;
        if (k == 0)
        begin : g_head
            assign s_in = samples.sample;
            assign a_in = '0;
        end
        else
        begin : g_body
            assign s_in = tap[k-1];
            assign a_in = acc[k-1];
        end
        tmaf_cell #(
            .IDX         (k),
            .WINDOW_MAX  (WINDOW_MAX),
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .shift      (shift),
            .m          (m_reg),
            .sample_in  (s_in),
            .sample_out (tap[k]),
            .acc_in     (a_in),
            .acc_out    (acc[k])
        );
    end

    tmaf_div #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (acc[WINDOW_MAX-1]),
        .divisor  (dsor),
        .status   (div_stat),
        .quotient (div_quo)
    );

    always_comb
    begin
        n_ext     = CW'(pos_reg);
        m_ext     = CW'(m_reg);
        at_center = n_ext >= m_ext;
        full      = n_ext >= (m_ext << 1);
        if (samples.last_of_frame)
        begin
            zeros = at_center ? WB'(m_reg) : WB'(pos_reg) + WB'(1);
        end
        else
        begin
            zeros = '0;
        end
        words  = WB'(at_center) + zeros;
        m_plus = DB'(m_reg) + DB'(1);
        dsor   = m_plus * m_plus;
    end

    always_comb
    begin
        state_next     = state_reg;
        m_next         = m_reg;
        pos_next       = pos_reg;
        cnt_next       = cnt_reg;
        pend_next      = pend_reg;
        eof_next       = eof_reg;
        value_next     = value_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_eof_next   = out_eof_reg;
        shift          = 1'b0;
        div_start      = 1'b0;
        load_out       = !out_valid_reg || results.ready;
        if (load_out)
        begin
            out_valid_next = 1'b0;
        end
        if (cfg_we)
        begin
            m_next = MB'(half_window(cfg_wdata, WINDOW_MAX));
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (samples.valid)
                begin
                    shift      = 1'b1;
                    value_next = '0;
                    eof_next   = samples.last_of_frame;
                    pend_next  = words;
                    if (samples.last_of_frame)
                    begin
                        pos_next = '0;
                    end
                    else if (pos_reg < PB'(WINDOW_MAX))
                    begin
                        pos_next = pos_reg + PB'(1);
                    end
                    if (at_center && full)
                    begin
                        state_next = ST_SUM;
                        cnt_next   = CB'(LAT);
                    end
                    else if (words != '0)
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_SUM:
            begin
                if (cnt_reg == '0)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
                else
                begin
                    cnt_next = cnt_reg - CB'(1);
                end
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    value_next = div_quo;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = value_reg;
                    out_eof_next   = eof_reg && (pend_reg == WB'(1));
                    value_next     = '0;
                    pend_next      = pend_reg - WB'(1);
                    if (pend_reg == WB'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            m_reg         <= M_RESET;
            pos_reg       <= '0;
            cnt_reg       <= '0;
            pend_reg      <= '0;
            eof_reg       <= 1'b0;
            value_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            out_eof_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            m_reg         <= m_next;
            pos_reg       <= pos_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            eof_reg       <= eof_next;
            value_reg     <= value_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
            out_eof_reg   <= out_eof_next;
        end
    end

    assign samples.ready        = (state_reg == ST_IDLE);
    assign results.valid        = out_valid_reg;
    assign results.smoothed     = out_data_reg;
    assign results.end_of_frame = out_eof_reg;

    a_div_from_sum: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(div_stat.busy) |-> $past(state_reg) == ST_SUM)
        else $error("divider started outside the summing phase");

    a_emit_has_words: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |-> pend_reg != '0)
        else $error("emit phase with no words pending");

    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (samples.valid && samples.ready && samples.last_of_frame) |=> pos_reg == '0)
        else $error("frame position not cleared after the last sample");

    a_idle_divider: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !div_stat.busy)
        else $error("divider busy while the filter is idle");

endmodule
